// File: rtl/mcss_pkg.sv
// ============================================================================
// MIDI channel state shadow package
// Shared constants, shadow slot map, store request type, the reset value of
// every shadow slot and the microcode ROM of the sequencer.
// ============================================================================
package mcss_pkg;

    // Channel and store geometry
    localparam int CHANNEL_COUNT = 16;
    localparam int CH_W          = 4;
    localparam int SLOT_W        = 4;
    localparam int SLOT_COUNT    = 13;
    localparam int DATA_W        = 14;
    localparam int MEM_DEPTH     = 2 ** (CH_W + SLOT_W);

    // Shadow slots within one channel row
    localparam logic [SLOT_W-1:0] S_PW    = 4'd0;
    localparam logic [SLOT_W-1:0] S_BANK  = 4'd1;
    localparam logic [SLOT_W-1:0] S_MOD   = 4'd2;
    localparam logic [SLOT_W-1:0] S_FOOT  = 4'd3;
    localparam logic [SLOT_W-1:0] S_VOL   = 4'd4;
    localparam logic [SLOT_W-1:0] S_PAN   = 4'd5;
    localparam logic [SLOT_W-1:0] S_BAL   = 4'd6;
    localparam logic [SLOT_W-1:0] S_EXPR  = 4'd7;
    localparam logic [SLOT_W-1:0] S_SUST  = 4'd8;
    localparam logic [SLOT_W-1:0] S_REV   = 4'd9;
    localparam logic [SLOT_W-1:0] S_CHO   = 4'd10;
    localparam logic [SLOT_W-1:0] S_XBANK = 4'd11;
    localparam logic [SLOT_W-1:0] S_PROG  = 4'd12;

    // Reset values
    localparam logic [DATA_W-1:0] MID_VALUE  = 14'h2000;
    localparam logic [DATA_W-1:0] EXPR_RESET = 14'h3F80;

    // Opcodes
    localparam logic [1:0] OP_MSG    = 2'd0;
    localparam logic [1:0] OP_REPLAY = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // MIDI status nibbles
    localparam logic [3:0] MT_NOTE_OFF = 4'h8;
    localparam logic [3:0] MT_NOTE_ON  = 4'h9;
    localparam logic [3:0] MT_CTRL     = 4'hB;
    localparam logic [3:0] MT_PROG     = 4'hC;
    localparam logic [3:0] MT_CHPRESS  = 4'hD;
    localparam logic [3:0] MT_PITCH    = 4'hE;

    // Volume controller number and scale reset
    localparam logic [6:0] CC_VOLUME    = 7'd7;
    localparam logic [7:0] SCALE_RESET  = 8'hFF;

    // Microcode program
    localparam int              PC_W      = 6;
    localparam logic [PC_W-1:0] PC_RST    = 6'd0;
    localparam logic [PC_W-1:0] PC_MSG    = 6'd1;
    localparam logic [PC_W-1:0] PC_REPLAY = 6'd4;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_FWD,
        EM_PW,
        EM_CTRL_HI,
        EM_CTRL_LO,
        EM_PROG
    } t_emit;

    typedef enum logic [1:0] {
        CD_NONE,
        CD_DROP,
        CD_NOPROG
    } t_cond;

    typedef enum logic {
        SS_WORD,
        SS_MSG
    } t_ssrc;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              clr;
        t_ssrc             ssrc;
        logic [SLOT_W-1:0] slot;
        t_emit             emit;
        logic [6:0]        ctrl;
        logic              scale;
        t_cond             cond;
        logic [PC_W-1:0]   target;
        logic              last;
        logic              fin;
    } t_uword;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              clr;
        logic [CH_W-1:0]   ch;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] wdata;
    } t_store_req;

    // Value a slot holds after reset or channel reset
    function automatic logic [DATA_W-1:0] slot_reset(input logic [SLOT_W-1:0] slot);
        logic [DATA_W-1:0] v;
        v = '0;
        case (slot)
            S_PW, S_MOD, S_VOL, S_PAN, S_BAL: v = MID_VALUE;
            S_EXPR:                           v = EXPR_RESET;
            default:                          v = '0;
        endcase
        return v;
    endfunction

    // Microcode ROM: one control word per step
    function automatic t_uword mc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w        = '0;
        w.ssrc   = SS_WORD;
        w.emit   = EM_NONE;
        w.cond   = CD_NONE;
        case (pc)
            // channel reset
            6'd0:  begin w.clr = 1'b1; w.fin = 1'b1; end
            // channel message: read, merge-write, forward
            6'd1:  begin w.rd = 1'b1; w.ssrc = SS_MSG; end
            6'd2:  begin w.wr = 1'b1; w.ssrc = SS_MSG; end
            6'd3:  begin
                w.emit = EM_FWD; w.cond = CD_DROP; w.last = 1'b1; w.fin = 1'b1;
            end
            // replay: pitch wheel
            6'd4:  begin w.rd = 1'b1; w.slot = S_PW; end
            6'd5:  begin w.emit = EM_PW; end
            // paired controllers, coarse then fine
            6'd6:  begin w.rd = 1'b1; w.slot = S_MOD; end
            6'd7:  begin w.emit = EM_CTRL_HI; w.ctrl = 7'd1; end
            6'd8:  begin w.emit = EM_CTRL_LO; w.ctrl = 7'd33; end
            6'd9:  begin w.rd = 1'b1; w.slot = S_FOOT; end
            6'd10: begin w.emit = EM_CTRL_HI; w.ctrl = 7'd4; end
            6'd11: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd36; end
            6'd12: begin w.rd = 1'b1; w.slot = S_VOL; end
            6'd13: begin w.emit = EM_CTRL_HI; w.ctrl = 7'd7; w.scale = 1'b1; end
            6'd14: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd39; end
            6'd15: begin w.rd = 1'b1; w.slot = S_PAN; end
            6'd16: begin w.emit = EM_CTRL_HI; w.ctrl = 7'd9; end
            6'd17: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd41; end
            6'd18: begin w.rd = 1'b1; w.slot = S_BAL; end
            6'd19: begin w.emit = EM_CTRL_HI; w.ctrl = 7'd10; end
            6'd20: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd42; end
            6'd21: begin w.rd = 1'b1; w.slot = S_EXPR; end
            6'd22: begin w.emit = EM_CTRL_HI; w.ctrl = 7'd11; end
            6'd23: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd43; end
            // single controllers
            6'd24: begin w.rd = 1'b1; w.slot = S_SUST; end
            6'd25: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd64; end
            6'd26: begin w.rd = 1'b1; w.slot = S_REV; end
            6'd27: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd91; end
            6'd28: begin w.rd = 1'b1; w.slot = S_CHO; end
            6'd29: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd93; end
            6'd30: begin w.rd = 1'b1; w.slot = S_XBANK; end
            6'd31: begin w.emit = EM_CTRL_LO; w.ctrl = 7'd114; end
            // program change, skipped when none recorded
            6'd32: begin w.rd = 1'b1; w.slot = S_PROG; end
            6'd33: begin w.emit = EM_PROG; w.cond = CD_NOPROG; w.target = 6'd34; end
            // bank select last
            6'd34: begin w.rd = 1'b1; w.slot = S_BANK; end
            6'd35: begin w.emit = EM_CTRL_HI; w.ctrl = 7'd0; end
            6'd36: begin
                w.emit = EM_CTRL_LO; w.ctrl = 7'd32; w.last = 1'b1; w.fin = 1'b1;
            end
            default: w.fin = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/mcss_store.sv
// ============================================================================
// MIDI channel state shadow store
// One 14-bit shadow memory addressed by channel and slot, with a valid bit per
// entry so that unwritten or reset entries read as their reset value.
// ============================================================================
module mcss_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcss_pkg::t_store_req          i_req,
    output logic [mcss_pkg::DATA_W-1:0]   o_rd_data
);
    import mcss_pkg::*;

    logic [DATA_W-1:0]     r_mem [MEM_DEPTH];
    logic [SLOT_COUNT-1:0] r_vld [CHANNEL_COUNT];
    logic [DATA_W-1:0]     r_q;
    logic                  r_q_vld;
    logic [SLOT_W-1:0]     r_q_slot;
    logic [CH_W+SLOT_W-1:0] addr;

    assign addr = {i_req.ch, i_req.slot};

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_q      <= r_mem[addr];
            r_q_vld  <= r_vld[i_req.ch][i_req.slot];
            r_q_slot <= i_req.slot;
        end
    end

    // per-entry valid bits; a channel reset drops the whole row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_vld[c] <= '0;
            end
        end else if (i_req.clr) begin
            r_vld[i_req.ch] <= '0;
        end else if (i_req.wr) begin
            r_vld[i_req.ch][i_req.slot] <= 1'b1;
        end
    end

    // invalid entries read as reset value
    assign o_rd_data = r_q_vld ? r_q : slot_reset(r_q_slot);

endmodule

// File: rtl/midi_channel_state_shadow.sv
// ============================================================================
// MIDI channel state shadow
// Tracks controller, program and pitch wheel state of 16 MIDI channels,
// forwards channel messages and replays or resets a channel's shadow.
// ============================================================================
// One item at a time: o_in_ready is high only while the sequencer is idle, and
// the sequencer runs from the cycle after the accepting edge. A channel message
// holds it through the read, merge-write and forward steps; a channel reset
// holds it through its clear step, and a replay for 19 or 20 beats, paced
// by the microcode program, which reads the single-port shadow memory once
// per stored slot and emits one beat per emitting step. A stalled output
// beat holds the sequencer at its next emitting step. Items that are not
// channel messages, or opcode 3, are taken and dropped at once.
// Coarse channel volume leaves scaled by floor(v * volume_scale / 255).
module midi_channel_state_shadow (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [3:0] i_msg_type,
    input  logic [3:0] i_channel,
    input  logic [6:0] i_data_first,
    input  logic [6:0] i_data_second,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_status,
    output logic [6:0] o_out_data_first,
    output logic [6:0] o_out_data_second,
    output logic       o_last_of_run
);
    import mcss_pkg::*;

    typedef enum logic [1:0] {
        CK_NONE,
        CK_COARSE,
        CK_FINE,
        CK_SINGLE
    } t_ckind;

    logic              r_busy;
    logic [PC_W-1:0]   r_pc;
    logic [3:0]        r_type;
    logic [CH_W-1:0]   r_ch;
    logic [6:0]        r_d1;
    logic [6:0]        r_d2;
    logic [7:0]        r_volume_scale;
    logic              r_out_valid;
    logic [7:0]        r_status;
    logic [6:0]        r_out_d1;
    logic [6:0]        r_out_d2;
    logic              r_last;

    t_uword            w;
    t_store_req        req;
    logic [DATA_W-1:0] q;
    t_ckind            ckind;
    logic [SLOT_W-1:0] cslot;
    logic [SLOT_W-1:0] msg_slot;
    logic              msg_wr;
    logic [DATA_W-1:0] msg_wdata;
    logic              drop;
    logic              cond_hit;
    logic              emit_req;
    logic              adv;
    logic              accept;
    logic              start;
    logic [PC_W-1:0]   entry_pc;
    logic [6:0]        scale_in;
    logic [14:0]       scale_prod;
    logic [14:0]       scale_sum;
    logic [6:0]        scaled;
    logic [7:0]        n_status;
    logic [6:0]        n_d1;
    logic [6:0]        n_d2;

    // current control word
    assign w = mc_rom(r_pc);

    // controller number to shadow slot
    always_comb begin
        ckind = CK_NONE;
        cslot = S_PW;
        unique case (r_d1)
            7'd0:    begin ckind = CK_COARSE; cslot = S_BANK;  end
            7'd32:   begin ckind = CK_FINE;   cslot = S_BANK;  end
            7'd1:    begin ckind = CK_COARSE; cslot = S_MOD;   end
            7'd33:   begin ckind = CK_FINE;   cslot = S_MOD;   end
            7'd4:    begin ckind = CK_COARSE; cslot = S_FOOT;  end
            7'd36:   begin ckind = CK_FINE;   cslot = S_FOOT;  end
            7'd7:    begin ckind = CK_COARSE; cslot = S_VOL;   end
            7'd39:   begin ckind = CK_FINE;   cslot = S_VOL;   end
            7'd9:    begin ckind = CK_COARSE; cslot = S_PAN;   end
            7'd41:   begin ckind = CK_FINE;   cslot = S_PAN;   end
            7'd10:   begin ckind = CK_COARSE; cslot = S_BAL;   end
            7'd42:   begin ckind = CK_FINE;   cslot = S_BAL;   end
            7'd11:   begin ckind = CK_COARSE; cslot = S_EXPR;  end
            7'd43:   begin ckind = CK_FINE;   cslot = S_EXPR;  end
            7'd64:   begin ckind = CK_SINGLE; cslot = S_SUST;  end
            7'd91:   begin ckind = CK_SINGLE; cslot = S_REV;   end
            7'd93:   begin ckind = CK_SINGLE; cslot = S_CHO;   end
            7'd114:  begin ckind = CK_SINGLE; cslot = S_XBANK; end
            default: begin ckind = CK_NONE;   cslot = S_PW;    end
        endcase
    end

    // message slot, write enable and merged write data
    always_comb begin
        msg_slot  = S_PW;
        msg_wr    = 1'b0;
        msg_wdata = q;
        case (r_type)
            MT_PITCH: begin
                msg_wr    = 1'b1;
                msg_wdata = {r_d2, r_d1};
            end
            MT_PROG: begin
                msg_slot  = S_PROG;
                msg_wr    = 1'b1;
                msg_wdata = {6'd0, 1'b1, r_d1};
            end
            MT_CTRL: begin
                msg_slot = cslot;
                msg_wr   = (ckind != CK_NONE);
                case (ckind)
                    CK_COARSE: msg_wdata = {r_d2, q[6:0]};
                    CK_FINE:   msg_wdata = {q[13:7], r_d2};
                    CK_SINGLE: msg_wdata = {7'd0, r_d2};
                    default:   msg_wdata = q;
                endcase
            end
            default: begin
                msg_slot = S_PW;
                msg_wr   = 1'b0;
            end
        endcase
    end

    // volume scaling: floor(p / 255) as (p + 1 + p/256) / 256, p at most 127*255
    assign scale_in   = (w.emit == EM_FWD) ? r_d2 : q[13:7];
    assign scale_prod = scale_in * r_volume_scale;
    assign scale_sum  = scale_prod + 15'd1 + {8'd0, scale_prod[14:8]};
    assign scaled     = scale_sum[14:8];

    // step conditions
    assign drop = (r_type == MT_NOTE_OFF) || ((r_type == MT_NOTE_ON) && (r_d2 == 7'd0));

    always_comb begin
        case (w.cond)
            CD_DROP:   cond_hit = drop;
            CD_NOPROG: cond_hit = !q[7];
            default:   cond_hit = 1'b0;
        endcase
    end

    assign emit_req = r_busy && (w.emit != EM_NONE) && !cond_hit;
    assign adv      = !(emit_req && r_out_valid && !i_out_ready);

    // beat payload for the current step
    always_comb begin
        n_status = {MT_CTRL, r_ch};
        n_d1     = w.ctrl;
        n_d2     = q[6:0];
        case (w.emit)
            EM_FWD: begin
                n_status = {r_type, r_ch};
                n_d1     = r_d1;
                if ((r_type == MT_PROG) || (r_type == MT_CHPRESS)) begin
                    n_d2 = 7'd0;
                end else if ((r_type == MT_CTRL) && (r_d1 == CC_VOLUME)) begin
                    n_d2 = scaled;
                end else begin
                    n_d2 = r_d2;
                end
            end
            EM_PW: begin
                n_status = {MT_PITCH, r_ch};
                n_d1     = q[6:0];
                n_d2     = q[13:7];
            end
            EM_CTRL_HI: n_d2 = w.scale ? scaled : q[13:7];
            EM_PROG: begin
                n_status = {MT_PROG, r_ch};
                n_d1     = q[6:0];
                n_d2     = 7'd0;
            end
            default: n_d2 = q[6:0];
        endcase
    end

    // store request
    always_comb begin
        req.rd    = r_busy && w.rd && adv;
        req.wr    = r_busy && w.wr && msg_wr && adv;
        req.clr   = r_busy && w.clr;
        req.ch    = r_ch;
        req.slot  = (w.ssrc == SS_MSG) ? msg_slot : w.slot;
        req.wdata = msg_wdata;
    end

    mcss_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (q)
    );

    // input acceptance and program entry point
    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        start    = 1'b0;
        entry_pc = PC_RST;
        case (i_opcode)
            OP_MSG: begin
                start    = (i_msg_type >= MT_NOTE_OFF) && (i_msg_type <= MT_PITCH);
                entry_pc = PC_MSG;
            end
            OP_REPLAY: begin
                start    = 1'b1;
                entry_pc = PC_REPLAY;
            end
            OP_RESET: begin
                start    = 1'b1;
                entry_pc = PC_RST;
            end
            default: begin
                start    = 1'b0;
                entry_pc = PC_RST;
            end
        endcase
        if ({1'b0, i_channel} >= 5'(CHANNEL_COUNT)) begin
            start = 1'b0;
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_pc           <= PC_RST;
            r_out_valid    <= 1'b0;
            r_volume_scale <= SCALE_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_volume_scale <= i_cfg_wr_data;
            end
            // a new beat may replace one that leaves at this edge
            if (emit_req && adv) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_busy <= start;
                r_pc   <= entry_pc;
                r_type <= i_msg_type;
                r_ch   <= i_channel;
                r_d1   <= i_data_first;
                r_d2   <= i_data_second;
            end else if (r_busy && adv) begin
                if (emit_req) begin
                    r_status    <= n_status;
                    r_out_d1    <= n_d1;
                    r_out_d2    <= n_d2;
                    r_last      <= w.last;
                end
                if (w.fin) begin
                    r_busy <= 1'b0;
                end else if (cond_hit) begin
                    r_pc <= w.target;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_status;
    assign o_out_data_first  = r_out_d1;
    assign o_out_data_second = r_out_d2;
    assign o_last_of_run     = r_last;

endmodule

// File: rtl/mcss_checker.sv
// ============================================================================
// MIDI channel state shadow checker
// Port-level checks of the output beat and the run sequencing.
// ============================================================================
module mcss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_opcode,
    input logic [3:0] i_msg_type,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_status,
    input logic [6:0] o_out_data_first,
    input logic [6:0] o_out_data_second,
    input logic       o_last_of_run
);
    import mcss_pkg::*;

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_status)
            && $stable(o_out_data_first) && $stable(o_out_data_second)
            && $stable(o_last_of_run))
        else $error("output beat changed while stalled");

    // every beat is a channel message
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_status[7] && (o_out_status[7:4] != 4'hF))
        else $error("beat status is not a channel message");

    // a started item blocks the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_REPLAY || i_opcode == OP_RESET
            || (i_opcode == OP_MSG && i_msg_type >= MT_NOTE_OFF
                && i_msg_type <= MT_PITCH))
        |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // a run is not over before its last beat
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |-> !o_in_ready)
        else $error("input ready in the middle of a run");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind midi_channel_state_shadow mcss_checker u_mcss_checker (.*);

// File: verif/midi_channel_state_shadow_check.sv
`timescale 1ns / 1ps
// ============================================================================
// MIDI channel state shadow checker
// Keeps its own copy of every channel's controller, program and pitch wheel
// state, works out the beats each accepted input beat must cause, and compares
// every accepted output beat, field by field, against the oldest one pending.
// ============================================================================
module midi_channel_state_shadow_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [3:0] i_msg_type,
    input  logic [3:0] i_channel,
    input  logic [6:0] i_data_first,
    input  logic [6:0] i_data_second,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_status,
    input  logic [6:0] i_out_data_first,
    input  logic [6:0] i_out_data_second,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_pending
);
    import mcss_pkg::*;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic       last;
    } t_midi_beat;

    // Paired controllers: coarse number, fine number is coarse + 32
    localparam int PAIR_COUNT   = 7;
    localparam int PAIR_BANK    = 0;
    localparam int PAIR_MOD     = 1;
    localparam int PAIR_FOOT    = 2;
    localparam int PAIR_VOL     = 3;
    localparam int PAIR_EXPR    = 6;
    localparam int SINGLE_COUNT = 4;
    localparam int RUN_MAX      = 20;

    localparam logic [PAIR_COUNT-1:0][6:0] PAIR_CC =
        {7'd11, 7'd10, 7'd9, CC_VOLUME, 7'd4, 7'd1, 7'd0};
    // sustain, reverb, chorus, extended bank
    localparam logic [SINGLE_COUNT-1:0][6:0] SINGLE_CC = {7'd114, 7'd93, 7'd91, 7'd64};
    localparam logic [6:0] FINE_OFFSET = 7'd32;
    localparam logic [3:0] MT_SYSTEM   = 4'hF;

    logic [7:0]        volume_scale;
    logic [DATA_W-1:0] pitch_store   [CHANNEL_COUNT];
    logic [7:0]        program_store [CHANNEL_COUNT];   // bit 7 = program seen
    logic [DATA_W-1:0] pair_store    [CHANNEL_COUNT][PAIR_COUNT];
    logic [6:0]        single_store  [CHANNEL_COUNT][SINGLE_COUNT];
    t_midi_beat        expected_beats [$];
    t_midi_beat        oldest_beat;

    initial o_fail_count = 0;

    // floor(v * scale / 255)
    function automatic logic [6:0] scaled_volume(input logic [6:0] v);
        logic [14:0] prod;
        prod = v * volume_scale;
        return 7'(prod / 15'd255);
    endfunction

    task automatic clear_channel(input int ch);
        pitch_store[ch]   = MID_VALUE;
        program_store[ch] = '0;
        for (int k = 0; k < PAIR_COUNT; k++) pair_store[ch][k] = MID_VALUE;
        pair_store[ch][PAIR_BANK] = '0;
        pair_store[ch][PAIR_FOOT] = '0;
        pair_store[ch][PAIR_EXPR] = EXPR_RESET;
        for (int k = 0; k < SINGLE_COUNT; k++) single_store[ch][k] = '0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns  shadow check, %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Update the shadow for one input beat and queue the beats it must cause
    task automatic shadow_apply(input logic [1:0] op, input logic [3:0] mt,
                                input logic [3:0] ch, input logic [6:0] d1,
                                input logic [6:0] d2);
        t_midi_beat run_beats [RUN_MAX];
        int         n;
        logic [6:0] fwd_second;
        logic [6:0] coarse;
        logic [7:0] ctrl_status;
        n           = 0;
        fwd_second  = d2;
        ctrl_status = {MT_CTRL, ch};
        if (op == OP_MSG && mt >= MT_NOTE_OFF && mt != MT_SYSTEM) begin
            if (mt == MT_CTRL) begin
                for (int k = 0; k < PAIR_COUNT; k++) begin
                    if (d1 == PAIR_CC[k]) begin
                        pair_store[ch][k][13:7] = d2;
                    end else if (d1 == PAIR_CC[k] + FINE_OFFSET) begin
                        pair_store[ch][k][6:0] = d2;
                    end
                end
                for (int k = 0; k < SINGLE_COUNT; k++) begin
                    if (d1 == SINGLE_CC[k]) single_store[ch][k] = d2;
                end
                if (d1 == CC_VOLUME) fwd_second = scaled_volume(d2);
            end else if (mt == MT_PROG) begin
                program_store[ch] = {1'b1, d1};
            end else if (mt == MT_PITCH) begin
                pitch_store[ch] = {d2, d1};
            end
            if (mt == MT_PROG || mt == MT_CHPRESS) fwd_second = '0;
            // note-off and silent note-on are swallowed
            if (!(mt == MT_NOTE_OFF || (mt == MT_NOTE_ON && d2 == '0))) begin
                run_beats[n] = {mt, ch, d1, fwd_second, 1'b0};
                n++;
            end
        end else if (op == OP_REPLAY) begin
            run_beats[n] = {MT_PITCH, ch, pitch_store[ch][6:0], pitch_store[ch][13:7], 1'b0};
            n++;
            for (int k = PAIR_MOD; k < PAIR_COUNT; k++) begin
                coarse = pair_store[ch][k][13:7];
                if (k == PAIR_VOL) coarse = scaled_volume(coarse);
                run_beats[n] = {ctrl_status, PAIR_CC[k], coarse, 1'b0};
                n++;
                run_beats[n] = {ctrl_status, PAIR_CC[k] + FINE_OFFSET,
                                pair_store[ch][k][6:0], 1'b0};
                n++;
            end
            for (int k = 0; k < SINGLE_COUNT; k++) begin
                run_beats[n] = {ctrl_status, SINGLE_CC[k], single_store[ch][k], 1'b0};
                n++;
            end
            if (program_store[ch][7]) begin
                run_beats[n] = {MT_PROG, ch, program_store[ch][6:0], 7'd0, 1'b0};
                n++;
            end
            // bank select goes out last
            run_beats[n] = {ctrl_status, PAIR_CC[PAIR_BANK],
                            pair_store[ch][PAIR_BANK][13:7], 1'b0};
            n++;
            run_beats[n] = {ctrl_status, PAIR_CC[PAIR_BANK] + FINE_OFFSET,
                            pair_store[ch][PAIR_BANK][6:0], 1'b0};
            n++;
        end else if (op == OP_RESET) begin
            clear_channel(ch);
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) run_beats[i].last = 1'b1;
            expected_beats.push_back(run_beats[i]);
        end
    endtask

    // Output beats are checked before the input beat of the same edge is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            volume_scale = SCALE_RESET;
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) clear_channel(ch);
            expected_beats.delete();
        end else begin
            if (i_cfg_wr_en) volume_scale = i_cfg_wr_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing pending, status", i_out_status, 0);
                end else begin
                    oldest_beat = expected_beats.pop_front();
                    if (i_out_status !== oldest_beat.status)
                        report_mismatch("status", i_out_status, oldest_beat.status);
                    if (i_out_data_first !== oldest_beat.data_first)
                        report_mismatch("data_first", i_out_data_first,
                                        oldest_beat.data_first);
                    if (i_out_data_second !== oldest_beat.data_second)
                        report_mismatch("data_second", i_out_data_second,
                                        oldest_beat.data_second);
                    if (i_last_of_run !== oldest_beat.last)
                        report_mismatch("last_of_run", i_last_of_run, oldest_beat.last);
                end
            end
            if (i_in_valid && i_in_ready)
                shadow_apply(i_opcode, i_msg_type, i_channel, i_data_first, i_data_second);
        end
        o_pending <= expected_beats.size();
    end

endmodule

// File: verif/midi_channel_state_shadow_test.sv
`timescale 1ns / 1ps
// ============================================================================
// MIDI channel state shadow testbench
// Directed channel messages, replays and channel resets, then random traffic
// in phases at different volume scales, with bursty input and a stalling
// output side. The checker instance predicts and compares every output beat.
// ============================================================================
module midi_channel_state_shadow_test;
    import mcss_pkg::*;

    localparam logic [1:0] OP_NONE       = 2'd3;
    localparam logic [3:0] MT_POLY_PRESS = 4'hA;
    localparam logic [3:0] MT_SYSTEM     = 4'hF;
    localparam int         QUIET_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_BEATS   = 20;

    // controller numbers the block keeps in its shadow
    localparam logic [17:0][6:0] STORED_CC = {
        7'd0, 7'd1, 7'd4, 7'd7, 7'd9, 7'd10, 7'd11, 7'd32, 7'd33,
        7'd36, 7'd39, 7'd41, 7'd42, 7'd43, 7'd64, 7'd91, 7'd93, 7'd114
    };

    typedef enum int {RX_OPEN, RX_MOSTLY_OPEN, RX_MOSTLY_STALLED, RX_PERIODIC} t_rx_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_opcode;
    logic [3:0] i_msg_type;
    logic [3:0] i_channel;
    logic [6:0] i_data_first;
    logic [6:0] i_data_second;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_status;
    logic [6:0] o_out_data_first;
    logic [6:0] o_out_data_second;
    logic       o_last_of_run;

    int fail_count;
    int pending_beats;
    int quiet_cycles = 0;
    int burst_left   = 0;

    midi_channel_state_shadow uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_msg_type       (i_msg_type),
        .i_channel        (i_channel),
        .i_data_first     (i_data_first),
        .i_data_second    (i_data_second),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_status     (o_out_status),
        .o_out_data_first (o_out_data_first),
        .o_out_data_second(o_out_data_second),
        .o_last_of_run    (o_last_of_run)
    );

    midi_channel_state_shadow_check shadow_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_msg_type       (i_msg_type),
        .i_channel        (i_channel),
        .i_data_first     (i_data_first),
        .i_data_second    (i_data_second),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_status     (o_out_status),
        .i_out_data_first (o_out_data_first),
        .i_out_data_second(o_out_data_second),
        .i_last_of_run    (o_last_of_run),
        .o_fail_count     (fail_count),
        .o_pending        (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Output side: stall pattern picked at random for spans of random length
    initial begin
        t_rx_mode rx_mode;
        int       span;
        int       tick;
        rx_mode = RX_OPEN;
        span    = 0;
        tick    = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                span    = $urandom_range(8, 80);
            end
            span--;
            tick++;
            case (rx_mode)
                RX_OPEN:           i_out_ready <= 1'b1;
                RX_MOSTLY_OPEN:    i_out_ready <= ($urandom_range(0, 3) != 0);
                RX_MOSTLY_STALLED: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:           i_out_ready <= (tick % 5 == 0);
            endcase
        end
    end

    // Watchdog: too long without any beat moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("midi_channel_state_shadow: mismatch");
            $finish;
        end
    end

    // One input beat; bursts of random length with random gaps between them
    task automatic send_item(input logic [1:0] op, input logic [3:0] mt,
                             input logic [3:0] ch, input logic [6:0] d1,
                             input logic [6:0] d2);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 10);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_msg_type    <= mt;
        i_channel     <= ch;
        i_data_first  <= d1;
        i_data_second <= d2;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold input until every pending beat is out and the block has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_volume_scale(input logic [7:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly channel messages on a few channels, some replays and resets,
    // and a little noise that the block drops
    task automatic send_random_item(output bit useful);
        int         pick;
        logic [1:0] op;
        logic [3:0] mt;
        logic [3:0] ch;
        logic [6:0] d1;
        logic [6:0] d2;
        pick   = $urandom_range(0, 99);
        ch     = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
                                             : 4'($urandom_range(0, 15));
        d1     = 7'($urandom);
        d2     = 7'($urandom);
        if ($urandom_range(0, 7) == 0) d2 = 7'h00;
        else if ($urandom_range(0, 7) == 0) d2 = 7'h7F;
        mt     = 4'($urandom);
        op     = OP_MSG;
        useful = 1'b1;
        if (pick < 70) begin
            mt = 4'($urandom_range(MT_NOTE_OFF, MT_PITCH));
            if (mt == MT_CTRL && $urandom_range(0, 2) != 0)
                d1 = STORED_CC[$urandom_range(0, 17)];
        end else if (pick < 82) begin
            op = OP_REPLAY;
        end else if (pick < 88) begin
            op = OP_RESET;
        end else begin
            useful = 1'b0;
            if ($urandom_range(0, 1) != 0) op = OP_NONE;
            else mt = ($urandom_range(0, 1) != 0) ? MT_SYSTEM : 4'($urandom_range(0, 7));
        end
        send_item(op, mt, ch, d1, d2);
    endtask

    initial begin
        int counted;
        bit useful;
        logic [7:0] scale;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_MSG;
        i_msg_type    <= MT_NOTE_OFF;
        i_channel     <= '0;
        i_data_first  <= '0;
        i_data_second <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, some stored controllers, every message type
        send_item(OP_REPLAY, MT_NOTE_OFF, 4'd0, 7'd0, 7'd0);
        send_item(OP_MSG, MT_CTRL, 4'd0, CC_VOLUME, 7'd127);
        send_item(OP_MSG, MT_CTRL, 4'd0, 7'd39, 7'd127);
        send_item(OP_MSG, MT_CTRL, 4'd15, 7'd64, 7'd127);
        send_item(OP_MSG, MT_CTRL, 4'd15, 7'd91, 7'd1);
        send_item(OP_MSG, MT_CTRL, 4'd15, 7'd93, 7'd2);
        send_item(OP_MSG, MT_CTRL, 4'd15, 7'd114, 7'd3);
        send_item(OP_MSG, MT_CTRL, 4'd15, 7'd0, 7'd5);
        send_item(OP_MSG, MT_CTRL, 4'd15, 7'd32, 7'd6);
        send_item(OP_MSG, MT_CTRL, 4'd15, 7'd127, 7'd127);
        send_item(OP_MSG, MT_NOTE_OFF, 4'd3, 7'd60, 7'd64);
        send_item(OP_MSG, MT_NOTE_ON, 4'd3, 7'd60, 7'd0);
        send_item(OP_MSG, MT_NOTE_ON, 4'd3, 7'd127, 7'd127);
        send_item(OP_MSG, MT_POLY_PRESS, 4'd3, 7'd0, 7'd127);
        send_item(OP_MSG, MT_PROG, 4'd15, 7'd127, 7'd55);
        send_item(OP_MSG, MT_CHPRESS, 4'd15, 7'd0, 7'd127);
        send_item(OP_MSG, MT_PITCH, 4'd15, 7'd127, 7'd0);
        send_item(OP_MSG, 4'h7, 4'd15, 7'd7, 7'd7);
        send_item(OP_MSG, MT_SYSTEM, 4'd15, 7'd7, 7'd7);
        send_item(OP_NONE, MT_CTRL, 4'd15, 7'd7, 7'd7);
        send_item(OP_REPLAY, MT_NOTE_OFF, 4'd15, 7'd0, 7'd0);
        send_item(OP_RESET, MT_NOTE_OFF, 4'd15, 7'd0, 7'd0);
        send_item(OP_REPLAY, MT_NOTE_OFF, 4'd15, 7'd0, 7'd0);
        send_item(OP_REPLAY, MT_NOTE_OFF, 4'd0, 7'd0, 7'd0);

        // random phases, each at its own volume scale
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0:       scale = 8'd0;
                1:       scale = 8'd255;
                2:       scale = 8'($urandom_range(2, 254));
                default: scale = 8'd1;
            endcase
            write_volume_scale(scale);
            counted = 0;
            while (counted < PHASE_BEATS) begin
                send_random_item(useful);
                if (useful) counted++;
            end
        end

        drain();
        repeat (24) @(posedge i_clk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("midi_channel_state_shadow: match");
        end else begin
            $display("midi_channel_state_shadow: mismatch");
        end
        $finish;
    end

endmodule
